// ----- hw/rtl/first_fit_block_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the first-fit block allocator
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define FFBA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define FFBA_ASSERT_IMP(label, clk, rst, a, c)
`define FFBA_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- hw/rtl/ffba_pkg.sv -----
// ---------------------------------------------------------------------------
// ffba_pkg
// shared constants of the first-fit block allocator
// ---------------------------------------------------------------------------
package ffba_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_END   = 1'b1;
endpackage

// ----- hw/rtl/first_fit_block_allocator.sv -----
// sequence: each table entry scanned takes a read state and a compare state, and each
//   entry shifted takes a read state and a write state, before the result beat
// throughput: one request at a time, the next input beat can be taken from the cycle after
//   the result beat unless a register write is pending; the single table memory port (one access a cycle) sets the pace
// reset: rst is synchronous, active high; clears block count and control, regions 0 and 65536
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator with an address-ordered table of blocks in a single-port memory
// ---------------------------------------------------------------------------
`include "first_fit_block_allocator_macros.svh"
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS    = 64,
  parameter int HEADER_BYTES  = 24,
  parameter int MANAGER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // command[0], request_size[32:1], free_address[64:33], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_address[31:0], status[34:32], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import ffba_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [33:0] HB = 34'(HEADER_BYTES);
  localparam logic [33:0] MB = 34'(MANAGER_BYTES);

  // states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;  // issue read of entry idx
  localparam logic [2:0] S_CHK   = 3'd2;  // compare with read data
  localparam logic [2:0] S_SHRD  = 3'd3;  // read entry for shifting
  localparam logic [2:0] S_SHWR  = 3'd4;  // write shifted entry
  localparam logic [2:0] S_INS   = 3'd5;  // write new entry
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state;
  logic [31:0] region_base, region_end;
  logic [CW-1:0] count, idx;
  logic        cmd;
  logic [31:0] req_size, req_addr;
  logic [33:0] cur_hdr, cur_size;   // running gap origin
  logic [31:0] res_addr;
  logic [2:0]  res_status;
  logic [31:0] new_hdr;

  // table memory, one port
  logic [63:0] mem [MAX_BLOCKS];
  logic [63:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // a register write takes priority over a request beat in idle
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {5'd0, res_status, res_addr};

  // gap test: next - cur - cur_size >= size + 2*hdr, signed 36-bit so nothing wraps
  logic signed [35:0] next_hdr;
  logic signed [35:0] gap, need;
  logic        fits, at_end;
  assign at_end   = (idx == count);
  assign next_hdr = at_end ? ($signed({4'b0, region_end}) - $signed({2'b0, HB}))
                           : $signed({4'b0, rd_data[31:0]});
  assign gap  = next_hdr - $signed({2'b0, cur_hdr}) - $signed({2'b0, cur_size});
  assign need = $signed({4'b0, req_size}) + $signed({2'b0, HB}) + $signed({2'b0, HB});
  assign fits = (gap >= need);

  // free range test
  logic bad_range;
  assign bad_range = ({2'b0, req_addr} < {2'b0, region_base} + HB) ||
                     ({2'b0, req_addr} + HB >= {2'b0, region_end});

  // a shift writes back the entry read the cycle before
  always_comb begin
    mem_we = 1'b0;
    mem_addr = idx[AW-1:0];
    mem_wdata = rd_data;
    unique case (state)
      S_SHRD:  mem_addr = (cmd == CMD_ALLOC) ? AW'(idx - 1'b1) : AW'(idx + 1'b1);
      S_SHWR:  mem_we = 1'b1;
      S_INS:   begin
        mem_we = 1'b1;
        mem_wdata = {req_size, new_hdr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      region_base <= 32'd0;
      region_end <= 32'd65536;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_BASE) region_base <= cfg_data;
            else region_end <= cfg_data;
            count <= '0;
          end else if (s_tvalid) begin
            cmd <= s_tdata[0];
            req_size <= s_tdata[32:1];
            req_addr <= s_tdata[64:33];
            res_addr <= '0;
            idx <= '0;
            cur_hdr <= {2'b0, region_base} + MB;
            cur_size <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (cmd == CMD_ALLOC && req_size == 32'd0) begin
            res_status <= ST_ZERO_SIZE; state <= S_OUT;
          end else if (cmd == CMD_ALLOC && count >= CW'(MAX_BLOCKS)) begin
            res_status <= ST_FULL; state <= S_OUT;
          end else if (cmd == CMD_FREE && bad_range) begin
            res_status <= ST_RANGE; state <= S_OUT;
          end else if (cmd == CMD_FREE && at_end) begin
            res_status <= ST_UNKNOWN; state <= S_OUT;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (cmd == CMD_ALLOC) begin
            if (fits) begin
              new_hdr <= 32'(cur_hdr + HB + cur_size);
              res_addr <= 32'(cur_hdr + HB + cur_size + HB);
              res_status <= ST_OK;
              // shift tail up from the top
              if (count == idx) state <= S_INS;
              else begin
                state <= S_SHRD;
                cmd <= CMD_ALLOC;
              end
              req_addr <= {{(32-CW){1'b0}}, idx};
              idx <= count;
            end else if (at_end) begin
              res_status <= ST_NO_SPACE; state <= S_OUT;
            end else begin
              cur_hdr <= {2'b0, rd_data[31:0]};
              cur_size <= {2'b0, rd_data[63:32]};
              idx <= idx + 1'b1;
              state <= S_RD;
            end
          end else begin
            if ({2'b0, rd_data[31:0]} + HB == {2'b0, req_addr}) begin
              res_status <= ST_OK;
              count <= count - 1'b1;
              if (idx + 1'b1 == count) state <= S_OUT;
              else state <= S_SHRD;
            end else begin
              idx <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          // rd_data holds the neighbor entry
          if (cmd == CMD_ALLOC) begin
            idx <= idx - 1'b1;
            if (idx - 1'b1 == req_addr[CW-1:0]) state <= S_INS;
            else state <= S_SHRD;
          end else begin
            idx <= idx + 1'b1;
            if (idx + 1'b1 == count) state <= S_OUT;
            else state <= S_SHRD;
          end
        end
        S_INS: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFBA_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= CW'(MAX_BLOCKS))
  `FFBA_ASSERT_IMP(a_busy, clk, rst, state != S_IDLE, !s_tready && !cfg_ready)
  `FFBA_ASSERT_IMP(a_fail_zero, clk, rst, m_tvalid && res_status != ST_OK, res_addr == 32'd0)
endmodule
